// ===== rtl/rts_pkg.sv =====
package rts_pkg;

  // fixed-point widths of the statistic datapath
  localparam int Q_W    = 64;  // Q.32 intermediates
  localparam int MB_W   = 33;  // multiplier operand b
  localparam int PROD_W = 97;  // Q_W + MB_W
  localparam int DIVN_W = 97;  // dividend bits
  localparam int DIVD_W = 34;  // divisor bits
  localparam int ROOT_W = 32;
  localparam int Z_W    = 28;
  localparam int ST_W   = 2;

  localparam logic [Z_W-1:0] Z_MAX = '1;
  localparam logic [Q_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [ST_W-1:0] ST_FLAT     = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_MUL_P,
    S_CHK,
    S_DIV_Q,
    S_DIV_R,
    S_MUL_V,
    S_SQRT,
    S_DIV_Z
  } rts_state_t;

endpackage

// ===== rtl/rts_mul.sv =====
// shift-add multiplier, one bit of b per cycle
module rts_mul #(
  parameter int A_W = 64,
  parameter int B_W = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CW = $clog2(B_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [A_W-1:0]     a_r, a_nxt;
  logic [A_W+B_W-1:0] acc_r, acc_nxt;
  logic [A_W:0]       sum;

  // add a into the high half when the low bit is set, then shift right
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    sum      = {1'b0, acc_r[A_W+B_W-1:B_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      acc_nxt  = {{A_W{1'b0}}, b};
    end else if (busy_r) begin
      acc_nxt = {sum, acc_r[B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/rts_div.sv =====
// restoring divider, one quotient bit per cycle
module rts_div #(
  parameter int NUM_W = 97,
  parameter int DEN_W = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // dividend bits shift out the top, quotient bits shift in the bottom
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/rts_sqrt.sv =====
// integer square root, two radicand bits per cycle
module rts_sqrt
  import rts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [Q_W-1:0]    v,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [Q_W-1:0]    v_r, v_nxt;
  logic [ROOT_W+2:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+2:0] sh;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    sh       = {rem_r[ROOT_W:0], v_r[Q_W-1:Q_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = sh >= trial;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = v;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? sh - trial : sh;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      v_nxt    = {v_r[Q_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/runs_test_statistic_unit.sv =====
// Runs test over a stream of symbol bytes. Symbols are taken one per cycle
// while a sequence is open; the item flagged last closes it and starts the
// bit-serial evaluation of |z| through a shared shift-add multiplier, a shared
// restoring divider and a square-root unit, during which no item is accepted.
// The result is registered from state S_LEN when the sequence is too short,
// from S_CHK on zero spread, from S_SQRT when the root truncates to zero,
// and from S_DIV_Z in the full case, which is spent mostly in the three
// 97-step divisions. The result sits in an output register;
// further symbols of the next sequence are taken while it waits, but its
// last item waits until the previous result is taken.
module runs_test_statistic_unit
  import rts_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_symbol,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [Z_W-1:0]  out_z_magnitude,
  output logic [ST_W-1:0] out_status
);

  localparam int N_W = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  rts_state_t state_r, state_nxt;

  logic [7:0]            prev_r;
  logic                  started_r, class_r, ovf_r;
  logic [COUNT_BITS-1:0] n0_r, n1_r, runs_r;
  logic [Q_W-1:0]        q_r, q_nxt;
  logic                  out_valid_r;
  logic [Z_W-1:0]        z_r;
  logic [ST_W-1:0]       st_r;

  logic                  in_acc, flip, cls;
  logic [N_W-1:0]        n_sum;
  logic [Q_W-1:0]        p_val, rq, d_val;
  logic [COUNT_BITS-1:0] runs_m1;

  logic                  mul_start, mul_done;
  logic [Q_W-1:0]        mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [PROD_W-1:0]     mul_prod;
  logic                  div_start, div_done;
  logic [DIVN_W-1:0]     div_num, div_quot;
  logic [DIVD_W-1:0]     div_den;
  logic                  sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]     sqrt_root;

  logic                  fin;
  logic [Z_W-1:0]        fin_z;
  logic [ST_W-1:0]       fin_st;
  logic [ST_W-1:0]       flat_st;

  assign in_ready = (state_r == S_IDLE) && !(out_valid_r && in_last);
  assign in_acc   = in_valid && in_ready;
  assign flip     = in_symbol != prev_r;
  assign cls      = class_r ^ flip;

  // datapath terms
  assign n_sum   = {1'b0, n0_r} + {1'b0, n1_r};
  assign p_val   = mul_prod[Q_W-1:0];
  assign runs_m1 = runs_r - 1'b1;
  assign rq      = Q_W'(runs_m1) << 32;
  assign d_val   = (rq >= q_r) ? rq - q_r : q_r - rq;
  assign flat_st = ovf_r ? ST_OVERFLOW : ST_FLAT;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_last) state_nxt = S_LEN;
      S_LEN:   state_nxt = (n_sum < N_W'(2)) ? S_IDLE : S_MUL_P;
      S_MUL_P: if (mul_done) state_nxt = S_CHK;
      S_CHK: begin
        if (p_val == '0 || {1'b0, p_val, 1'b0} == 66'(n_sum)) state_nxt = S_IDLE;
        else state_nxt = S_DIV_Q;
      end
      S_DIV_Q: if (div_done) state_nxt = S_DIV_R;
      S_DIV_R: if (div_done) state_nxt = S_MUL_V;
      S_MUL_V: if (mul_done) state_nxt = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) state_nxt = (sqrt_root == '0) ? S_IDLE : S_DIV_Z;
      end
      S_DIV_Z: if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit launches and result selection
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = Q_W'(n0_r);
    mul_b      = MB_W'(n1_r);
    div_start  = 1'b0;
    div_num    = {p_val, 33'd0};
    div_den    = DIVD_W'(n_sum);
    sqrt_start = 1'b0;
    fin        = 1'b0;
    fin_z      = '0;
    fin_st     = flat_st;
    q_nxt      = q_r;
    unique case (state_r)
      S_IDLE: ;
      S_LEN: begin
        if (n_sum < N_W'(2)) begin
          fin    = 1'b1;
          fin_st = ST_SHORT;
        end else begin
          mul_start = 1'b1;
        end
      end
      S_MUL_P: ;
      S_CHK: begin
        if (p_val == '0 || {1'b0, p_val, 1'b0} == 66'(n_sum)) fin = 1'b1;
        else div_start = 1'b1;
      end
      S_DIV_Q: begin
        q_nxt   = div_quot[Q_W-1:0];
        div_num = DIVN_W'(div_quot[Q_W-1:0] - ONE_Q32);
        div_den = DIVD_W'(n_sum - 1'b1);
        if (div_done) div_start = 1'b1;
        else q_nxt = q_r;
      end
      S_DIV_R: begin
        mul_a = q_r;
        mul_b = div_quot[MB_W-1:0];
        if (div_done) mul_start = 1'b1;
      end
      S_MUL_V: if (mul_done) sqrt_start = 1'b1;
      S_SQRT: begin
        div_num = DIVN_W'(d_val);
        div_den = DIVD_W'(sqrt_root);
        if (sqrt_done) begin
          if (sqrt_root == '0) fin = 1'b1;
          else div_start = 1'b1;
        end
      end
      S_DIV_Z: begin
        fin_z  = (div_quot[DIVN_W-1:Z_W] != '0) ? Z_MAX : div_quot[Z_W-1:0];
        fin_st = ovf_r ? ST_OVERFLOW : ST_OK;
        fin    = div_done;
      end
      default: ;
    endcase
  end

  // sequence counters, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      class_r     <= 1'b0;
      ovf_r       <= 1'b0;
      n0_r        <= '0;
      n1_r        <= '0;
      runs_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_acc) begin
        prev_r <= in_symbol;
        if (!started_r) begin
          started_r <= 1'b1;
          class_r   <= 1'b0;
          n0_r      <= COUNT_BITS'(1);
          n1_r      <= '0;
          runs_r    <= COUNT_BITS'(1);
          ovf_r     <= 1'b0;
        end else begin
          class_r <= cls;
          if (flip && runs_r != CNT_MAX) runs_r <= runs_r + 1'b1;
          if (!cls && n0_r != CNT_MAX) n0_r <= n0_r + 1'b1;
          if (cls && n1_r != CNT_MAX) n1_r <= n1_r + 1'b1;
          // any counter pinned at its top marks the sequence
          if ((flip && runs_r == CNT_MAX) || (!cls && n0_r == CNT_MAX) ||
              (cls && n1_r == CNT_MAX)) ovf_r <= 1'b1;
        end
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        started_r   <= 1'b0;
        class_r     <= 1'b0;
        ovf_r       <= 1'b0;
        n0_r        <= '0;
        n1_r        <= '0;
        runs_r      <= '0;
        prev_r      <= '0;
      end
    end
    q_r <= q_nxt;
    if (fin) begin
      z_r  <= fin_z;
      st_r <= fin_st;
    end
  end

  rts_mul #(.A_W(Q_W), .B_W(MB_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rts_div #(.NUM_W(DIVN_W), .DEN_W(DIVD_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  rts_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (mul_prod[Q_W+31:32]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign out_valid       = out_valid_r;
  assign out_z_magnitude = z_r;
  assign out_status      = st_r;

endmodule

// ===== rtl/rts_checker.sv =====
// port-level checks for the runs test unit
module rts_checker
  import rts_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_last,
  input logic            out_valid,
  input logic            out_ready,
  input logic [Z_W-1:0]  out_z_magnitude,
  input logic [ST_W-1:0] out_status
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_z_magnitude) && $stable(out_status))
    else $error("result changed while stalled");

  // short and flat sequences report a zero score
  a_zero_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_FLAT) |-> out_z_magnitude == '0)
    else $error("nonzero score with degenerate status");

  // a closing item starts the evaluation, so input stalls next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after a last item");

  // the last item of a sequence never overtakes a pending result
  a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_valid && in_last |-> !in_ready)
    else $error("last item taken while result pending");

endmodule

bind runs_test_statistic_unit rts_checker u_rts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_z_magnitude (out_z_magnitude),
  .out_status      (out_status)
);

// ===== bench/runs_test_statistic_unit_test.sv =====
`timescale 1ns / 100ps

module runs_test_statistic_unit_test
  import rts_pkg::*;
();

  localparam int COUNT_BITS = 20;
  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
    bit         hold_until_drained;
  } symbol_item_t;

  typedef struct {
    logic [Z_W-1:0]  z_magnitude;
    logic [ST_W-1:0] status;
  } z_result_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_symbol;
  logic            in_last;
  logic            out_valid;
  logic            out_ready;
  logic [Z_W-1:0]  out_z_magnitude;
  logic [ST_W-1:0] out_status;

  symbol_item_t pending_symbols[$];
  z_result_t    expected_z[$];
  int           mismatch_count = 0;
  int           accepted_items = 0;
  int           results_seen = 0;
  int           phase = 0;
  int           hold_off_left = 0;
  bit           hold_off_done = 0;

  // predictor state
  logic [7:0]  prev_sym;
  bit          seq_open;
  bit          cur_class;
  logic [63:0] n0_count, n1_count, runs_count;
  bit          count_saturated;

  runs_test_statistic_unit #(.COUNT_BITS(COUNT_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_symbol(in_symbol), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_z_magnitude(out_z_magnitude), .out_status(out_status)
  );

  // clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic logic [63:0] count_up(logic [63:0] x);
    if (x >= COUNT_TOP) begin
      count_saturated = 1;
      return COUNT_TOP;
    end
    return x + 64'd1;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // running runs-test prediction, one call per accepted item
  task automatic predict_runs(input logic [7:0] sym, input logic last);
    logic [63:0]  n, p, q, r, v, s, rq, d, z, lo_prod;
    logic [127:0] wide;
    logic [ST_W-1:0] st;
    z_result_t res;
    if (!seq_open) begin
      seq_open = 1; cur_class = 0; n0_count = 1; n1_count = 0;
      runs_count = 1; count_saturated = 0;
    end else begin
      if (sym != prev_sym) begin
        cur_class = ~cur_class;
        runs_count = count_up(runs_count);
      end
      if (!cur_class) n0_count = count_up(n0_count);
      else n1_count = count_up(n1_count);
    end
    prev_sym = sym;
    if (!last) return;
    n = n0_count + n1_count;
    z = 0;
    if (n <= 1) begin
      st = ST_SHORT;
    end else begin
      p = n0_count * n1_count;
      st = count_saturated ? ST_OVERFLOW : ST_FLAT;
      if (p != 0 && (2 * p != n)) begin
        wide = {64'd0, p} << 33;
        wide = wide / {64'd0, n};
        q = wide[63:0];
        r = (q - ONE_Q32) / (n - 64'd1);
        lo_prod = {32'd0, q[31:0]} * r;
        v = (q >> 32) * r + (lo_prod >> 32);
        s = int_sqrt(v);
        if (s != 0) begin
          rq = (runs_count - 64'd1) << 32;
          d = (rq >= q) ? (rq - q) : (q - rq);
          z = d / s;
          if (z > {36'd0, Z_MAX}) z = {36'd0, Z_MAX};
          if (!count_saturated) st = ST_OK;
        end
      end
    end
    res.z_magnitude = z[Z_W-1:0];
    res.status = st;
    expected_z.push_back(res);
    seq_open = 0; cur_class = 0; n0_count = 0; n1_count = 0;
    runs_count = 0; count_saturated = 0; prev_sym = 0;
  endtask

  task automatic add_symbol(input logic [7:0] sym, input logic last, input bit hold);
    symbol_item_t it;
    it.symbol = sym; it.last = last; it.hold_until_drained = hold;
    pending_symbols.push_back(it);
  endtask

  // sender idle percentage per phase
  function automatic int sender_idle_pct();
    case (phase)
      1: return 73;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_runs(in_symbol, in_last);
        accepted_items++;
        phase <= ((accepted_items - 1) / 200) % 4;
      end
      if (pending_symbols.size() != 0 &&
          !(pending_symbols[0].hold_until_drained &&
            (expected_z.size() != 0 || (in_valid && in_last))) &&
          $urandom_range(99) >= sender_idle_pct()) begin
        in_valid  <= 1'b1;
        in_symbol <= pending_symbols[0].symbol;
        in_last   <= pending_symbols[0].last;
        void'(pending_symbols.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_off_done && results_seen == 12) begin
      hold_off_done <= 1;
      hold_off_left <= 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= ((phase == 2 || phase == 3) ?
                   (phase == 2 ? 73 : 21) : 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    z_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_z.size() == 0) begin
        $display("%0t: unexpected result z=%0d status=%0d", $time,
                 out_z_magnitude, out_status);
        mismatch_count++;
      end else begin
        want = expected_z.pop_front();
        if (want.z_magnitude !== out_z_magnitude) begin
          $display("%0t: z_magnitude expected %0d actual %0d", $time,
                   want.z_magnitude, out_z_magnitude);
          mismatch_count++;
        end
        if (want.status !== out_status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int len, alpha, total, i;
    logic [7:0] base;
    in_valid = 0; in_symbol = 0; in_last = 0; out_ready = 0;
    seq_open = 0; cur_class = 0; n0_count = 0; n1_count = 0;
    runs_count = 0; count_saturated = 0; prev_sym = 0;
    rst_n = 0;
    // directed sequences: too short, flat, balanced pair, extremes
    add_symbol(8'h00, 1, 0);
    add_symbol(8'hFF, 1, 0);
    add_symbol(8'h41, 0, 0); add_symbol(8'h41, 1, 0);
    add_symbol(8'h00, 0, 0); add_symbol(8'hFF, 1, 0);
    add_symbol(8'hFF, 0, 0); add_symbol(8'h00, 0, 0); add_symbol(8'hFF, 1, 0);
    for (i = 0; i < 8; i++) add_symbol((i % 2) ? 8'hFF : 8'h00, i == 7, 0);
    add_symbol(8'h55, 0, 0); add_symbol(8'h55, 0, 0); add_symbol(8'hAA, 0, 0);
    add_symbol(8'hAA, 0, 0); add_symbol(8'h55, 1, 0);
    // random sequences, mostly small alphabets so runs are frequent
    total = 0;
    while (total < 1350) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      alpha = $urandom_range(3) == 0 ? 256 : $urandom_range(1, 3);
      base = 8'($urandom);
      for (i = 0; i < len; i++)
        add_symbol((alpha == 256) ? 8'($urandom) : 8'(base + $urandom_range(alpha - 1)),
                   i == len - 1, (i == 0) && (total > 600) && (total < 700));
      total += len;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    while (pending_symbols.size() != 0 || in_valid) @(posedge clk);
    while (expected_z.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatch_count == 0 && expected_z.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // timeout
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rts_pkg.sv
rtl/rts_mul.sv
rtl/rts_div.sv
rtl/rts_sqrt.sv
rtl/runs_test_statistic_unit.sv
rtl/rts_checker.sv
bench/runs_test_statistic_unit_test.sv
